// File: sv/speck_pkg.sv
// Shared types and constants for the Speck128/256 cipher core.
package speck_pkg;

	localparam int WORD_W    = 64;
	localparam int KEY_WORDS = 4;
	localparam int KEY_IDX_W = 2;
	localparam int ROT_ALPHA = 8;
	localparam int ROT_BETA  = 3;

	localparam logic KIND_ENC = 1'b0;
	localparam logic KIND_DEC = 1'b1;

	typedef struct packed {
		logic              kind;
		logic [WORD_W-1:0] block_low;
		logic [WORD_W-1:0] block_high;
	} speck_in_t;

	typedef struct packed {
		logic [WORD_W-1:0] result_low;
		logic [WORD_W-1:0] result_high;
	} speck_out_t;

	typedef struct packed {
		logic              kind;
		logic [WORD_W-1:0] x0;
		logic [WORD_W-1:0] x1;
		logic [WORD_W-1:0] k;
	} speck_round_in_t;

	typedef struct packed {
		logic [WORD_W-1:0] x0;
		logic [WORD_W-1:0] x1;
	} speck_round_out_t;

endpackage

// File: sv/speck_round.sv
// One Speck round, forward or inverse; also serves the key schedule step.
module speck_round (
	input  speck_pkg::speck_round_in_t  rin,
	output speck_pkg::speck_round_out_t rout
);
	import speck_pkg::*;

	logic [WORD_W-1:0] enc_x1;
	logic [WORD_W-1:0] enc_x0;
	logic [WORD_W-1:0] dec_mix;
	logic [WORD_W-1:0] dec_x0;
	logic [WORD_W-1:0] dec_diff;
	logic [WORD_W-1:0] dec_x1;

	always_comb begin
		// forward: x1 = (x1 >>> 8) + x0 ^ k ; x0 = (x0 <<< 3) ^ x1
		enc_x1 = ((rin.x1 >> ROT_ALPHA) | (rin.x1 << (WORD_W - ROT_ALPHA))) + rin.x0;
		enc_x1 = enc_x1 ^ rin.k;
		enc_x0 = ((rin.x0 << ROT_BETA) | (rin.x0 >> (WORD_W - ROT_BETA))) ^ enc_x1;
		// inverse round
		dec_mix  = rin.x0 ^ rin.x1;
		dec_x0   = (dec_mix >> ROT_BETA) | (dec_mix << (WORD_W - ROT_BETA));
		dec_diff = (rin.x1 ^ rin.k) - dec_x0;
		dec_x1   = (dec_diff << ROT_ALPHA) | (dec_diff >> (WORD_W - ROT_ALPHA));
		if (rin.kind == KIND_DEC) begin
			rout.x0 = dec_x0;
			rout.x1 = dec_x1;
		end else begin
			rout.x0 = enc_x0;
			rout.x1 = enc_x1;
		end
	end

endmodule

// File: sv/speck_128_256_block_cipher.sv
// Speck128/256 cipher core: iterative, one round per cycle on a shared round unit.
//
// Usage:
//   Key: four 64-bit words written through cfg_we/cfg_index/cfg_data, index 0
//   holds key bits 63..0. Every key write restarts the key expansion, which
//   runs through the round unit and fills the round key RAM; in_ready stays
//   low until it is done.
//   Reset clears the key to zero and runs the same expansion before the
//   first block is taken.
//   Input: one transfer on in_valid/in_ready carries a block and the
//   direction (kind 0 encrypt, 1 decrypt). The core then works on that block
//   alone: a prime state starts the round key read, then ROUND_COUNT rounds
//   run one per cycle, limited by the single round unit and the RAM read port.
//   Output: the result is held in an output register, which the done state
//   loads once the register is free; out_valid rises with that load.
//   A new block may be accepted while a result waits. If out_ready is still
//   low when the next block finishes, the core holds it until the output
//   register frees. A new block is taken only once the last has reached the output register.
module speck_128_256_block_cipher #(
	parameter int ROUND_COUNT = 34
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  speck_pkg::speck_in_t                  in_data,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output speck_pkg::speck_out_t                 out_data,
	input  logic                                  cfg_we,
	input  logic [speck_pkg::KEY_IDX_W-1:0]       cfg_index,
	input  logic [speck_pkg::WORD_W-1:0]          cfg_data
);
	import speck_pkg::*;

	localparam int AW = (ROUND_COUNT > 1) ? $clog2(ROUND_COUNT) : 1;
	localparam logic [AW-1:0] LAST = AW'(ROUND_COUNT - 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PRIME,
		ST_RUN,
		ST_DONE
	} state_t;

	state_t            state_q;
	logic [AW-1:0]     rnd_cnt_q;
	logic              dir_q;
	logic [WORD_W-1:0] x0_q;
	logic [WORD_W-1:0] x1_q;
	logic [WORD_W-1:0] rk_q;
	logic              out_valid_q;
	speck_out_t        out_data_q;

	logic [WORD_W-1:0] key_q [KEY_WORDS];
	logic              exp_pend_q;
	logic              exp_run_q;
	logic [AW-1:0]     exp_cnt_q;
	logic [WORD_W-1:0] a_q;
	logic [WORD_W-1:0] l0_q;
	logic [WORD_W-1:0] l1_q;
	logic [WORD_W-1:0] l2_q;

	logic [WORD_W-1:0] rk_mem [ROUND_COUNT];

	speck_round_in_t   rin;
	speck_round_out_t  rout;
	logic              in_xfer;
	logic              rd_en;
	logic [AW-1:0]     rd_step;
	logic [AW-1:0]     rd_addr;

	speck_round u_round (
		.rin  (rin),
		.rout (rout)
	);

	assign in_ready  = (state_q == ST_IDLE) && !exp_run_q && !exp_pend_q && !cfg_we;
	assign in_xfer   = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// schedule step is a forward round with the round index as key
	always_comb begin
		if (exp_run_q) begin
			rin.kind = KIND_ENC;
			rin.x0   = a_q;
			rin.x1   = l0_q;
			rin.k    = WORD_W'(exp_cnt_q);
		end else begin
			rin.kind = dir_q;
			rin.x0   = x0_q;
			rin.x1   = x1_q;
			rin.k    = rk_q;
		end
	end

	// prefetch the round key for the next round
	always_comb begin
		rd_en   = (state_q == ST_PRIME) || ((state_q == ST_RUN) && (rnd_cnt_q != LAST));
		rd_step = (state_q == ST_PRIME) ? '0 : (rnd_cnt_q + AW'(1));
		rd_addr = (dir_q == KIND_DEC) ? (LAST - rd_step) : rd_step;
	end

	always_ff @(posedge clk) begin
		if (exp_run_q) begin
			rk_mem[exp_cnt_q] <= a_q;
		end
		if (rd_en) begin
			rk_q <= rk_mem[rd_addr];
		end
	end

	// key registers and schedule sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < KEY_WORDS; i++) begin
				key_q[i] <= '0;
			end
			exp_pend_q <= 1'b1;
			exp_run_q  <= 1'b0;
			exp_cnt_q  <= '0;
		end else begin
			if (cfg_we) begin
				key_q[cfg_index] <= cfg_data;
			end
			if (exp_pend_q) begin
				exp_pend_q <= cfg_we;
				exp_run_q  <= 1'b1;
				exp_cnt_q  <= '0;
				a_q        <= key_q[0];
				l0_q       <= key_q[1];
				l1_q       <= key_q[2];
				l2_q       <= key_q[3];
			end else begin
				exp_pend_q <= cfg_we;
				if (exp_run_q) begin
					a_q  <= rout.x0;
					l0_q <= l1_q;
					l1_q <= l2_q;
					l2_q <= rout.x1;
					if (exp_cnt_q == LAST) begin
						exp_run_q <= 1'b0;
					end else begin
						exp_cnt_q <= exp_cnt_q + AW'(1);
					end
				end
			end
		end
	end

	// block sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rnd_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						x0_q      <= in_data.block_low;
						x1_q      <= in_data.block_high;
						dir_q     <= in_data.kind;
						rnd_cnt_q <= '0;
						state_q   <= ST_PRIME;
					end
				end
				ST_PRIME: begin
					state_q <= ST_RUN;
				end
				ST_RUN: begin
					x0_q <= rout.x0;
					x1_q <= rout.x1;
					if (rnd_cnt_q == LAST) begin
						state_q <= ST_DONE;
					end else begin
						rnd_cnt_q <= rnd_cnt_q + AW'(1);
					end
				end
				ST_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_data_q.result_low  <= x0_q;
						out_data_q.result_high <= x1_q;
						out_valid_q            <= 1'b1;
						state_q                <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_no_block_during_expand: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |-> !exp_run_q && !exp_pend_q)
		else $error("block transfer while key expansion pending");

	a_expand_ends: assert property (@(posedge clk) disable iff (!arst_n)
		exp_run_q && (exp_cnt_q == LAST) |=> !exp_run_q || (exp_cnt_q == '0))
		else $error("key expansion overran the round count");

	a_round_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RUN |-> rnd_cnt_q <= LAST)
		else $error("round counter out of range");

	a_done_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE) && (!out_valid_q || out_ready) |=>
			out_valid_q && (state_q == ST_IDLE))
		else $error("finished block not moved to output register");
`endif

endmodule

// File: dv/speck_128_256_block_cipher_test.sv
// Self-checking testbench for the Speck128/256 cipher core: predicts every block and checks it.
module speck_128_256_block_cipher_test;
	timeunit 1ns;
	timeprecision 1ps;

	import speck_pkg::*;

	localparam int ROUNDS          = 34;
	localparam int CLK_PERIOD      = 10;
	localparam int KEY_SPAN        = 34;   // blocks sent under one key in random traffic
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int SETTLE_CYCLES   = ROUNDS + 8;

	typedef logic [WORD_W-1:0] word_t;

	typedef enum int {
		KEY_WORD0,
		KEY_WORD1,
		KEY_WORD2,
		KEY_WORD3
	} key_reg_e;

	localparam logic [KEY_WORDS-1:0] ALL_KEY_WORDS = '1;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 in_valid  = 1'b0;
	logic                 in_ready;
	speck_in_t            in_data   = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	speck_out_t           out_data;
	logic                 cfg_we    = 1'b0;
	logic [KEY_IDX_W-1:0] cfg_index = '0;
	word_t                cfg_data  = '0;

	// predictor state
	word_t       key_shadow [KEY_WORDS];
	word_t       round_keys [ROUNDS];
	speck_out_t  pending_results [$];
	int unsigned mismatch_count = 0;

	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	int unsigned hold_off_req  = 0;

	speck_128_256_block_cipher #(
		.ROUND_COUNT(ROUNDS)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic word_t rotl(input word_t v, input int unsigned s);
		return (v << s) | (v >> (WORD_W - s));
	endfunction

	function automatic word_t rotr(input word_t v, input int unsigned s);
		return (v >> s) | (v << (WORD_W - s));
	endfunction

	// key schedule: same add-rotate-xor round with the round index as key
	function automatic void expand_round_keys();
		word_t a;
		word_t l [3];
		word_t nl;
		a = key_shadow[0];
		l[0] = key_shadow[1];
		l[1] = key_shadow[2];
		l[2] = key_shadow[3];
		for (int r = 0; r < ROUNDS; r++) begin
			round_keys[r] = a;
			nl = (rotr(l[0], ROT_ALPHA) + a) ^ word_t'(r);
			a = rotl(a, ROT_BETA) ^ nl;
			l[0] = l[1];
			l[1] = l[2];
			l[2] = nl;
		end
	endfunction

	function automatic speck_out_t cipher_block(input speck_in_t item);
		word_t x0;
		word_t x1;
		speck_out_t res;
		x0 = item.block_low;
		x1 = item.block_high;
		if (item.kind == KIND_DEC) begin
			for (int r = 0; r < ROUNDS; r++) begin
				x0 = rotr(x0 ^ x1, ROT_BETA);
				x1 = rotl((x1 ^ round_keys[ROUNDS - 1 - r]) - x0, ROT_ALPHA);
			end
		end else begin
			for (int r = 0; r < ROUNDS; r++) begin
				x1 = (rotr(x1, ROT_ALPHA) + x0) ^ round_keys[r];
				x0 = rotl(x0, ROT_BETA) ^ x1;
			end
		end
		res.result_low  = x0;
		res.result_high = x1;
		return res;
	endfunction

	// mostly random, with a fair share of all-zero and all-one words
	function automatic word_t random_word();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic logic random_kind();
		return $urandom_range(1) ? KIND_DEC : KIND_ENC;
	endfunction

	// one block, with random idle cycles before it; valid stays up after the transfer
	task automatic send_block(input logic kind, input word_t lo, input word_t hi);
		speck_in_t item;
		item.kind       = kind;
		item.block_low  = lo;
		item.block_high = hi;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= item;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		pending_results.push_back(cipher_block(item));
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// writes the selected key words back to back; call only with the core idle
	task automatic load_key(input logic [KEY_WORDS-1:0] mask,
				input word_t w0, input word_t w1, input word_t w2, input word_t w3);
		word_t words [KEY_WORDS];
		words = '{w0, w1, w2, w3};
		for (int i = 0; i < KEY_WORDS; i++) begin
			if (mask[i]) begin
				cfg_we    <= 1'b1;
				cfg_index <= KEY_IDX_W'(i);
				cfg_data  <= words[i];
				@(posedge clk);
				key_shadow[i] = words[i];
			end
		end
		cfg_we <= 1'b0;
		expand_round_keys();
	endtask

	// receiver: random stalls, plus a long hold-off whenever one is requested
	initial begin : receiver
		int unsigned served;
		served = 0;
		forever begin
			@(posedge clk);
			if (hold_off_req != served) begin
				served = hold_off_req;
				for (int n = 0; n < HOLD_OFF_CYCLES; n++) begin
					out_ready <= 1'b0;
					@(posedge clk);
				end
			end
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		speck_out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$error("result with no block pending: low %h high %h",
					out_data.result_low, out_data.result_high);
				mismatch_count++;
			end else begin
				want = pending_results.pop_front();
				if (out_data.result_low !== want.result_low) begin
					$error("result_low: expected %h, got %h",
						want.result_low, out_data.result_low);
					mismatch_count++;
				end
				if (out_data.result_high !== want.result_high) begin
					$error("result_high: expected %h, got %h",
						want.result_high, out_data.result_high);
					mismatch_count++;
				end
			end
		end
	end

	// reset key is all zero: extremes and alternating patterns both ways
	task automatic test_zero_key_blocks();
		send_block(KIND_ENC, '0, '0);
		send_block(KIND_DEC, '0, '0);
		send_block(KIND_ENC, '1, '1);
		send_block(KIND_DEC, '1, '1);
		send_block(KIND_ENC, {WORD_W/2{2'b10}}, {WORD_W/2{2'b01}});
		send_block(KIND_DEC, {WORD_W/2{2'b01}}, {WORD_W/2{2'b10}});
		drain_results();
	endtask

	task automatic test_ones_key_blocks();
		load_key(ALL_KEY_WORDS, '1, '1, '1, '1);
		send_block(KIND_ENC, '0, '1);
		send_block(KIND_DEC, '1, '0);
		send_block(KIND_ENC, '1, '1);
		send_block(KIND_DEC, '0, '0);
		drain_results();
	endtask

	// a single register write must re-expand the whole schedule
	task automatic test_partial_key_update();
		load_key(KEY_WORDS'(1 << KEY_WORD2), '0, '0, 64'h0123_4567_89ab_cdef, '0);
		send_block(KIND_ENC, 64'h0000_0000_0000_0001, '0);
		send_block(KIND_DEC, '0, 64'h8000_0000_0000_0000);
		drain_results();
		load_key(KEY_WORDS'(1 << KEY_WORD0), 64'hfedc_ba98_7654_3210, '0, '0, '0);
		send_block(KIND_ENC, 64'h8000_0000_0000_0000, '1);
		send_block(KIND_DEC, '1, 64'h0000_0000_0000_0001);
		drain_results();
	endtask

	// encrypt a block, then decrypt the predicted ciphertext
	task automatic test_round_trip();
		speck_in_t plain;
		speck_out_t sealed;
		load_key(ALL_KEY_WORDS, 64'h0706_0504_0302_0100, 64'h0f0e_0d0c_0b0a_0908,
			64'h1716_1514_1312_1110, 64'h1f1e_1d1c_1b1a_1918);
		plain.kind       = KIND_ENC;
		plain.block_low  = 64'h6573_6f68_7420_6e49;
		plain.block_high = 64'h202e_7265_6e6f_6f70;
		sealed = cipher_block(plain);
		send_block(KIND_ENC, plain.block_low, plain.block_high);
		send_block(KIND_DEC, sealed.result_low, sealed.result_high);
		drain_results();
	endtask

	task automatic test_random_traffic(input int unsigned send_pct, input int unsigned recv_pct,
					   input int unsigned item_count);
		logic [KEY_WORDS-1:0] mask;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		for (int n = 0; n < item_count; n++) begin
			if (n % KEY_SPAN == 0) begin
				drain_results();
				mask = $urandom_range(1) ? ALL_KEY_WORDS : KEY_WORDS'($urandom_range(1, 15));
				load_key(mask, random_word(), random_word(), random_word(), random_word());
			end
			send_block(random_kind(), random_word(), random_word());
		end
		drain_results();
	endtask

	// long receiver hold-off while blocks keep coming: the core must stall its input
	task automatic test_output_backpressure();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_off_req++;
		for (int n = 0; n < 12; n++)
			send_block(random_kind(), random_word(), random_word());
		drain_results();
	endtask

	initial begin
		for (int i = 0; i < KEY_WORDS; i++)
			key_shadow[i] = '0;
		expand_round_keys();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		test_zero_key_blocks();
		test_ones_key_blocks();
		test_partial_key_update();
		test_round_trip();
		test_random_traffic(28, 46, 170);
		test_random_traffic(46, 28, 170);
		test_random_traffic(0, 0, 170);
		test_output_backpressure();

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && pending_results.size() == 0) begin
			$display("speck_128_256_block_cipher_test passed");
		end else begin
			$display("speck_128_256_block_cipher_test failed");
		end
		$finish;
	end

	initial begin
		#(CLK_PERIOD * 200_000);
		$display("speck_128_256_block_cipher_test failed");
		$finish;
	end

endmodule
